### rtl/core/ssp_pkg.sv
// ssp_pkg: types, constants and helpers for the substring presence search.
// Used by ssp_cell and substring_presence_search. No dependencies.
package ssp_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int BYTE_W              = 8;
   localparam int PATTERN_W           = 64;
   localparam int LEN_W               = 5;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 64;
   localparam int BYTES_PER_WORD      = PATTERN_W / BYTE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } link_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } ctrl_type;

   // pattern positions sixteen and up read as zero
   function automatic logic [BYTE_W-1:0] pattern_byte(
      input logic [PATTERN_W-1:0] lo,
      input logic [PATTERN_W-1:0] hi,
      input logic [LEN_W-1:0]     idx
   );
      logic [BYTE_W-1:0] b;
      b = '0;
      if (idx < LEN_W'(BYTES_PER_WORD)) begin
         b = lo[idx[2:0]*BYTE_W +: BYTE_W];
      end else if (idx < LEN_W'(2 * BYTES_PER_WORD)) begin
         b = hi[idx[2:0]*BYTE_W +: BYTE_W];
      end
      return b;
   endfunction

endpackage

### rtl/core/ssp_cell.sv
// ssp_cell: one window position; holds a byte and its valid bit, passes them on.
// Depends on ssp_pkg.
module ssp_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ssp_pkg::ctrl_type              ctrl,
   input  ssp_pkg::link_type              link_in,
   input  logic [ssp_pkg::PATTERN_W-1:0]  pattern_low,
   input  logic [ssp_pkg::PATTERN_W-1:0]  pattern_high,
   input  logic [ssp_pkg::LEN_W-1:0]      eff_length,
   output ssp_pkg::link_type              link_out,
   output logic                           hit
);

   ssp_pkg::link_type             link_ff;
   ssp_pkg::link_type             link_in_next;
   logic                          active;
   logic [ssp_pkg::LEN_W-1:0]     pat_idx;
   logic [ssp_pkg::BYTE_W-1:0]    pat_byte;

   // window entry k is compared with pattern byte (len-1-k)
   assign active   = int'(eff_length) > CELL_INDEX;
   assign pat_idx  = eff_length - ssp_pkg::LEN_W'(CELL_INDEX) - ssp_pkg::LEN_W'(1);
   assign pat_byte = ssp_pkg::pattern_byte(pattern_low, pattern_high, pat_idx);
   assign hit      = !active || (link_in.valid && (link_in.data == pat_byte));

   always_comb begin
      link_in_next = link_ff;
      if (ctrl.clear) begin
         link_in_next.valid = 1'b0;
      end else if (ctrl.shift) begin
         link_in_next = link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_next.valid;
      end
      link_ff.data <= link_in_next.data;
   end

   assign link_out = link_ff;

endmodule

### rtl/core/substring_presence_search.sv
// substring_presence_search: streamed byte text, reports whether a pattern occurs.
// Depends on ssp_pkg and ssp_cell.
//
//   channel | ports                              | direction
//   req     | req_valid/ready, text_byte, end    | in, one text byte per item
//   rsp     | rsp_valid/ready, rsp_found         | out, one item per text end
//   csr     | csr_write_enable, index, data      | in, pattern registers
//
// One byte per cycle; a row of MAX_PATTERN cells shifts the window and all
// active cells compare in the cycle the byte is taken. found is registered
// and shows in the cycle after the last byte is taken. req_ready drops only
// while a result waits and rsp_ready is low. Synchronous reset clears window
// valid bits, the match flag, the result valid bit and the pattern registers.
module substring_presence_search #(
   parameter int MAX_PATTERN = ssp_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ssp_pkg::BYTE_W-1:0]       req_text_byte,
   input  logic                             req_text_end,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   input  logic                             csr_write_enable,
   input  logic [ssp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssp_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [ssp_pkg::PATTERN_W-1:0] pattern_low_ff;
   logic [ssp_pkg::PATTERN_W-1:0] pattern_high_ff;
   logic [ssp_pkg::LEN_W-1:0]     pattern_length_ff;
   logic [ssp_pkg::LEN_W-1:0]     eff_length;
   logic                          match_seen_ff, match_seen_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          accept;
   logic                          hit_all;
   ssp_pkg::ctrl_type             ctrl;
   ssp_pkg::link_type             links [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0]        hits;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ssp_pkg::CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_data;
            end
            ssp_pkg::CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_data;
            end
            ssp_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_data[ssp_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign eff_length = (int'(pattern_length_ff) > MAX_PATTERN) ?
                       ssp_pkg::LEN_W'(MAX_PATTERN) : pattern_length_ff;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign ctrl.shift = accept;
   assign ctrl.clear = accept && req_text_end;

   assign links[0].valid = 1'b1;
   assign links[0].data  = req_text_byte;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      ssp_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .link_in      (links[k]),
         .pattern_low  (pattern_low_ff),
         .pattern_high (pattern_high_ff),
         .eff_length   (eff_length),
         .link_out     (links[k+1]),
         .hit          (hits[k])
      );
   end

   assign hit_all = &hits;

   always_comb begin
      match_seen_in = match_seen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      if (accept) begin
         if (req_text_end) begin
            match_seen_in = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_found_in  = match_seen_ff || hit_all;
         end else begin
            match_seen_in = match_seen_ff || hit_all;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         match_seen_ff <= match_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule
